// File: hdl/tlex_pkg.sv
// Shared constants, types and trie functions of the token lexer.
`default_nettype none
package tlex_pkg;

    localparam int LookDepth = 8;
    localparam int LineBits  = 16;
    localparam int QDepth    = LookDepth + 2;
    localparam int CntW      = $clog2(LookDepth + 1);
    localparam int IdxW      = $clog2(LookDepth);
    localparam int QLenW     = $clog2(QDepth + 1);
    localparam int MaxRes    = 10;
    localparam int NemW      = $clog2(MaxRes + 1);

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_BAR     = 3'd1;
    localparam logic [2:0] MODE_COMMENT = 3'd2;
    localparam logic [2:0] MODE_STRING  = 3'd3;
    localparam logic [2:0] MODE_ESCAPE  = 3'd4;
    localparam logic [2:0] MODE_NAME    = 3'd5;
    localparam logic [2:0] MODE_PUNCT   = 3'd6;

    localparam logic [4:0] KIND_BAD    = 5'd0;
    localparam logic [4:0] KIND_END    = 5'd1;
    localparam logic [4:0] KIND_STRING = 5'd2;
    localparam logic [4:0] KIND_NAME   = 5'd3;
    localparam logic [4:0] KIND_BAR    = 5'd19;

    typedef struct packed {
        logic load;
        logic proc;
        logic res_emit;
        logic res_req;
        logic fin_mode;
        logic end_tok;
        logic close;
    } t_cmd;

    typedef struct packed {
        logic go;
        logic q_empty;
        logic is_punct;
        logic resolve_hit;
        logic emit_last;
        logic req_done;
        logic pend_valid;
    } t_stat;

    // Bit 5 set when the edge exists; bits 4..0 the next node.
    function automatic logic [5:0] trie_next(input logic [4:0] node, input logic [7:0] c);
        logic [5:0] r;
        r = 6'd0;
        case (node)
            5'd0: begin
                case (c)
                    "(": r = {1'b1, 5'd1};
                    "+": r = {1'b1, 5'd2};
                    ")": r = {1'b1, 5'd3};
                    ",": r = {1'b1, 5'd4};
                    ":": r = {1'b1, 5'd5};
                    ";": r = {1'b1, 5'd8};
                    "=": r = {1'b1, 5'd9};
                    "-": r = {1'b1, 5'd11};
                    "~": r = {1'b1, 5'd13};
                    "{": r = {1'b1, 5'd15};
                    "}": r = {1'b1, 5'd16};
                    "[": r = {1'b1, 5'd17};
                    "]": r = {1'b1, 5'd18};
                    "%": r = {1'b1, 5'd19};
                    default: r = 6'd0;
                endcase
            end
            5'd5:  if (c == ":") r = {1'b1, 5'd6};
            5'd6:  if (c == "=") r = {1'b1, 5'd7};
            5'd9:  if (c == "=") r = {1'b1, 5'd10};
            5'd11: if (c == ">") r = {1'b1, 5'd12};
            5'd13: if (c == "=") r = {1'b1, 5'd14};
            5'd19: if (c == "i") r = {1'b1, 5'd20};
            5'd20: if (c == "n") r = {1'b1, 5'd21};
            5'd21: if (c == "c") r = {1'b1, 5'd22};
            5'd22: if (c == "l") r = {1'b1, 5'd23};
            5'd23: if (c == "u") r = {1'b1, 5'd24};
            5'd24: if (c == "d") r = {1'b1, 5'd25};
            5'd25: if (c == "e") r = {1'b1, 5'd26};
            default: r = 6'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] node_kind(input logic [4:0] node);
        logic [4:0] k;
        case (node)
            5'd1:  k = 5'd4;
            5'd2:  k = 5'd5;
            5'd3:  k = 5'd6;
            5'd4:  k = 5'd7;
            5'd5:  k = 5'd8;
            5'd7:  k = 5'd9;
            5'd8:  k = 5'd10;
            5'd9:  k = 5'd13;
            5'd10: k = 5'd11;
            5'd12: k = 5'd12;
            5'd14: k = 5'd14;
            5'd15: k = 5'd15;
            5'd16: k = 5'd16;
            5'd17: k = 5'd17;
            5'd18: k = 5'd18;
            5'd26: k = 5'd20;
            default: k = 5'd0;
        endcase
        return k;
    endfunction

    function automatic logic node_leaf(input logic [4:0] node);
        logic l;
        case (node)
            5'd0, 5'd5, 5'd6, 5'd9, 5'd11, 5'd13, 5'd19, 5'd20, 5'd21,
            5'd22, 5'd23, 5'd24, 5'd25: l = 1'b0;
            default: l = 1'b1;
        endcase
        return l;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_alpha(c) || (c >= "0" && c <= "9");
    endfunction

    function automatic logic [7:0] esc_map(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            "b":     r = 8'd8;
            "f":     r = 8'd12;
            "n":     r = 8'd10;
            "r":     r = 8'd13;
            "t":     r = 8'd9;
            default: r = c;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hdl/token_lexer_stream.sv
// Top level of the streaming tokenizer: controller, datapath and stream ports.
//
//  port group  dir  tdata                               tuser       tlast
//  s_axis      in   char_code[7:0]                      -           end_mark
//  m_axis      out  text_byte, first, last_tok, line,   token_kind  last_of_run
//                   string_broken
//
//  A source byte is accepted and lexed step by step; the controller then sees
//  the queue empty and closes the run. A failed punctuation match emits the
//  matched bytes and replays the rest before lexing goes on; an end-of-input
//  beat flushes any open match or mode, then emits an end token and closes.
//  The newest result waits in a pending stage until a newer one or the close.
//  Reset is synchronous; the line count restarts at 1. A stalled output
//  freezes the controller whenever the pending stage and output are both full.
`default_nettype none
module token_lexer_stream
    import tlex_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [7:0] text_byte, [8] first_of_token,
                                             // [9] last_of_token, [25:10] line_number,
                                             // [26] string_broken
    output logic [4:0]       m_axis_tuser,   // [4:0] token_kind
    output logic             m_axis_tlast
);

    t_cmd        cmd;
    t_stat       stat;
    logic [7:0]  out_byte;
    logic        out_first, out_last_tok, out_broken;
    logic [15:0] out_line;

    tlex_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_end   (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tlex_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_byte   (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_kind      (m_axis_tuser),
        .o_byte      (out_byte),
        .o_first     (out_first),
        .o_last_tok  (out_last_tok),
        .o_last_run  (m_axis_tlast),
        .o_line      (out_line),
        .o_broken    (out_broken)
    );

    assign m_axis_tdata = {5'd0, out_broken, out_line, out_last_tok, out_first, out_byte};

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (stat.q_empty && !stat.pend_valid))
        else $error("input taken with work still queued");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.proc, cmd.res_emit, cmd.res_req, cmd.fin_mode, cmd.end_tok,
                  cmd.close}))
        else $error("more than one datapath command");

    a_end_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("end of input not flushed");

endmodule
`default_nettype wire

// File: hdl/tlex_datapath.sv
// Lexer datapath: mode and match registers, lookahead, replay queue, result stages.
`default_nettype none
module tlex_datapath
    import tlex_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_stat                      o_stat,
    input  wire logic [7:0]            i_in_byte,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output logic [4:0]                 o_kind,
    output logic [7:0]                 o_byte,
    output logic                       o_first,
    output logic                       o_last_tok,
    output logic                       o_last_run,
    output logic [15:0]                o_line,
    output logic                       o_broken
);

    logic [2:0]          r_mode, n_mode;
    logic [4:0]          r_node, n_node;
    logic [7:0]          r_buf [LookDepth];
    logic [CntW-1:0]     r_cnt, n_cnt;
    logic [CntW-1:0]     r_best_len, n_best_len;
    logic [4:0]          r_best_kind, n_best_kind;
    logic [CntW-1:0]     r_ridx, n_ridx;
    logic [8:0]          r_held, n_held;
    logic                r_hfirst, n_hfirst;
    logic [LineBits-1:0] r_line, n_line;
    logic [7:0]          r_q [QDepth];
    logic [QLenW-1:0]    r_qlen;
    logic [NemW-1:0]     r_nemit;

    logic                r_pend_valid;
    logic [4:0]          r_pend_kind;
    logic [7:0]          r_pend_byte;
    logic                r_pend_first, r_pend_last, r_pend_broken;
    logic [15:0]         r_pend_line;
    logic                r_out_valid;

    logic [7:0]          c;
    logic [LineBits-1:0] line_inc;
    logic                is_p;
    logic [4:0]          base_node;
    logic [CntW-1:0]     base_cnt, base_blen, p_cnt1;
    logic [4:0]          base_bkind;
    logic [5:0]          tn;
    logic                p_fail;
    logic [4:0]          p_kind;
    logic                p_leaf;
    logic                best_ok;
    logic [CntW-1:0]     res_k;
    logic [IdxW-1:0]     rd_idx;
    logic [7:0]          buf_rd;
    logic                buf_we;
    logic                consume, prepend, hit;
    logic                emit_req, emit_do;
    logic [4:0]          e_kind;
    logic [7:0]          e_byte;
    logic                e_first, e_last, e_broken;
    logic [LineBits-1:0] e_line;
    logic                go;

    assign c        = r_q[0];
    assign line_inc = (r_line != '1) ? r_line + LineBits'(1) : r_line;

    assign is_p       = (r_mode == MODE_PUNCT);
    assign base_node  = is_p ? r_node : 5'd0;
    assign base_cnt   = is_p ? r_cnt : '0;
    assign base_blen  = is_p ? r_best_len : '0;
    assign base_bkind = is_p ? r_best_kind : 5'd0;
    assign tn         = trie_next(base_node, c);
    assign p_fail     = !tn[5] || (base_cnt >= CntW'(LookDepth));
    assign p_cnt1     = base_cnt + CntW'(1);
    assign p_kind     = node_kind(tn[4:0]);
    assign p_leaf     = node_leaf(tn[4:0]);

    assign best_ok = (r_best_len != '0) && (r_best_len <= r_cnt);
    assign res_k   = best_ok ? r_best_len : CntW'(1);
    assign rd_idx  = i_cmd.res_req ? IdxW'(r_ridx - CntW'(1)) : IdxW'(r_ridx);
    assign buf_rd  = r_buf[rd_idx];

    assign go = !r_pend_valid || !r_out_valid || i_out_ready;

    always_comb begin
        n_mode      = r_mode;
        n_node      = r_node;
        n_cnt       = r_cnt;
        n_best_len  = r_best_len;
        n_best_kind = r_best_kind;
        n_ridx      = r_ridx;
        n_held      = r_held;
        n_hfirst    = r_hfirst;
        n_line      = r_line;
        buf_we      = 1'b0;
        consume     = 1'b0;
        prepend     = 1'b0;
        hit         = 1'b0;
        emit_req    = 1'b0;
        e_kind      = KIND_BAD;
        e_byte      = 8'd0;
        e_first     = 1'b1;
        e_last      = 1'b1;
        e_broken    = 1'b0;
        e_line      = r_line;

        if (i_cmd.proc) begin
            case (r_mode)
                MODE_BAR: begin
                    if (c == "|") begin
                        n_mode  = MODE_COMMENT;
                        consume = 1'b1;
                    end else begin
                        // lone bar: emit it and relex this byte
                        emit_req = 1'b1;
                        e_kind   = KIND_BAR;
                        e_byte   = "|";
                        n_mode   = MODE_IDLE;
                    end
                end
                MODE_COMMENT: begin
                    consume = 1'b1;
                    if (c == 8'd10) begin
                        n_line = line_inc;
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_STRING: begin
                    consume = 1'b1;
                    if (c == 8'd10 || c == "\"") begin
                        emit_req = 1'b1;
                        e_kind   = KIND_STRING;
                        e_byte   = r_held[8] ? r_held[7:0] : 8'd0;
                        e_first  = r_held[8] ? r_hfirst : 1'b1;
                        e_broken = (c == 8'd10);
                        n_held   = 9'd0;
                        n_hfirst = 1'b0;
                        n_mode   = MODE_IDLE;
                        if (c == 8'd10) n_line = line_inc;
                    end else if (c == "\\") begin
                        n_mode = MODE_ESCAPE;
                    end else begin
                        emit_req = r_held[8];
                        e_kind   = KIND_STRING;
                        e_byte   = r_held[7:0];
                        e_first  = r_hfirst;
                        e_last   = 1'b0;
                        if (r_held[8]) n_hfirst = 1'b0;
                        n_held   = {1'b1, c};
                    end
                end
                MODE_ESCAPE: begin
                    consume = 1'b1;
                    // an escaped newline is counted before the held byte leaves
                    if (c == 8'd10) begin
                        n_line = line_inc;
                        e_line = line_inc;
                    end
                    emit_req = r_held[8];
                    e_kind   = KIND_STRING;
                    e_byte   = r_held[7:0];
                    e_first  = r_hfirst;
                    e_last   = 1'b0;
                    if (r_held[8]) n_hfirst = 1'b0;
                    n_held   = {1'b1, esc_map(c)};
                    n_mode   = MODE_STRING;
                end
                MODE_NAME: begin
                    emit_req = 1'b1;
                    e_kind   = KIND_NAME;
                    if (is_alnum(c)) begin
                        consume  = 1'b1;
                        emit_req = r_held[8];
                        e_byte   = r_held[7:0];
                        e_first  = r_hfirst;
                        e_last   = 1'b0;
                        if (r_held[8]) n_hfirst = 1'b0;
                        n_held   = {1'b1, c};
                    end else begin
                        e_byte   = r_held[8] ? r_held[7:0] : 8'd0;
                        e_first  = r_held[8] ? r_hfirst : 1'b1;
                        n_held   = 9'd0;
                        n_hfirst = 1'b0;
                        n_mode   = MODE_IDLE;
                    end
                end
                MODE_IDLE, MODE_PUNCT: begin
                    if (!is_p && c == "|") begin
                        n_mode  = MODE_BAR;
                        consume = 1'b1;
                    end else if (!is_p && c == 8'd10) begin
                        n_line  = line_inc;
                        consume = 1'b1;
                    end else if (!is_p && (c == " " || c == 8'd9 || c == 8'd11 ||
                                           c == 8'd12 || c == 8'd13)) begin
                        consume = 1'b1;
                    end else if (!is_p && c == "\"") begin
                        n_mode   = MODE_STRING;
                        n_held   = 9'd0;
                        n_hfirst = 1'b1;
                        consume  = 1'b1;
                    end else if (!is_p && is_alpha(c)) begin
                        n_mode   = MODE_NAME;
                        n_held   = {1'b1, c};
                        n_hfirst = 1'b1;
                        consume  = 1'b1;
                    end else if (is_p || tn[5]) begin
                        if (p_fail) begin
                            // keep the byte queued; resolve the match first
                            hit = 1'b1;
                        end else begin
                            consume     = 1'b1;
                            buf_we      = 1'b1;
                            n_cnt       = p_cnt1;
                            n_node      = tn[4:0];
                            n_mode      = MODE_PUNCT;
                            n_best_len  = (p_kind != 5'd0) ? p_cnt1 : base_blen;
                            n_best_kind = (p_kind != 5'd0) ? p_kind : base_bkind;
                            hit         = p_leaf;
                        end
                    end else begin
                        consume  = 1'b1;
                        emit_req = 1'b1;
                        e_kind   = KIND_BAD;
                        e_byte   = c;
                    end
                end
                default: begin
                    n_mode = MODE_IDLE;
                end
            endcase
        end

        if (i_cmd.res_emit) begin
            emit_req = 1'b1;
            e_kind   = best_ok ? r_best_kind : KIND_BAD;
            e_byte   = buf_rd;
            e_first  = (r_ridx == '0);
            e_last   = (r_ridx == res_k - CntW'(1));
            n_ridx   = e_last ? r_cnt : r_ridx + CntW'(1);
        end

        if (i_cmd.res_req) begin
            if (r_ridx > res_k) begin
                prepend = 1'b1;
                n_ridx  = r_ridx - CntW'(1);
            end else begin
                n_ridx      = '0;
                n_cnt       = '0;
                n_best_len  = '0;
                n_best_kind = 5'd0;
                n_node      = 5'd0;
                n_mode      = MODE_IDLE;
            end
        end

        if (i_cmd.fin_mode) begin
            case (r_mode)
                MODE_BAR: begin
                    emit_req = 1'b1;
                    e_kind   = KIND_BAR;
                    e_byte   = "|";
                end
                MODE_STRING, MODE_ESCAPE, MODE_NAME: begin
                    emit_req = 1'b1;
                    e_kind   = (r_mode == MODE_NAME) ? KIND_NAME : KIND_STRING;
                    e_byte   = r_held[8] ? r_held[7:0] : 8'd0;
                    e_first  = r_held[8] ? r_hfirst : 1'b1;
                    e_broken = (r_mode != MODE_NAME);
                end
                default: begin
                    emit_req = 1'b0;
                end
            endcase
        end

        if (i_cmd.end_tok) begin
            emit_req    = 1'b1;
            e_kind      = KIND_END;
            n_mode      = MODE_IDLE;
            n_node      = 5'd0;
            n_cnt       = '0;
            n_best_len  = '0;
            n_best_kind = 5'd0;
            n_ridx      = '0;
            n_held      = 9'd0;
            n_hfirst    = 1'b0;
            n_line      = LineBits'(1);
        end
    end

    assign emit_do = emit_req && (r_nemit < NemW'(MaxRes));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_node      <= 5'd0;
            r_cnt       <= '0;
            r_best_len  <= '0;
            r_best_kind <= 5'd0;
            r_ridx      <= '0;
            r_held      <= 9'd0;
            r_hfirst    <= 1'b0;
            r_line      <= LineBits'(1);
        end else begin
            r_mode      <= n_mode;
            r_node      <= n_node;
            r_cnt       <= n_cnt;
            r_best_len  <= n_best_len;
            r_best_kind <= n_best_kind;
            r_ridx      <= n_ridx;
            r_held      <= n_held;
            r_hfirst    <= n_hfirst;
            r_line      <= n_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (buf_we) r_buf[IdxW'(base_cnt)] <= c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen <= '0;
        end else if (i_cmd.load) begin
            r_q[0] <= i_in_byte;
            r_qlen <= QLenW'(1);
        end else if (i_cmd.end_tok) begin
            r_qlen <= '0;
        end else if (consume) begin
            for (int i = 0; i < QDepth - 1; i++) r_q[i] <= r_q[i + 1];
            r_qlen <= r_qlen - QLenW'(1);
        end else if (prepend && r_qlen < QLenW'(QDepth)) begin
            for (int i = 1; i < QDepth; i++) r_q[i] <= r_q[i - 1];
            r_q[0] <= buf_rd;
            r_qlen <= r_qlen + QLenW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nemit <= '0;
        end else if (i_cmd.close) begin
            r_nemit <= '0;
        end else if (emit_do) begin
            r_nemit <= r_nemit + NemW'(1);
        end
    end

    // pending stage holds the newest item until it is known whether it ends the run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if ((emit_do || i_cmd.close) && r_pend_valid) begin
                r_out_valid <= 1'b1;
                o_kind      <= r_pend_kind;
                o_byte      <= r_pend_byte;
                o_first     <= r_pend_first;
                o_last_tok  <= r_pend_last;
                o_line      <= r_pend_line;
                o_broken    <= r_pend_broken;
                o_last_run  <= i_cmd.close;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (emit_do) begin
                r_pend_valid  <= 1'b1;
                r_pend_kind   <= e_kind;
                r_pend_byte   <= e_byte;
                r_pend_first  <= e_first;
                r_pend_last   <= e_last;
                r_pend_broken <= e_broken;
                r_pend_line   <= 16'(e_line);
            end else if (i_cmd.close) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    assign o_stat = '{go:          go,
                      q_empty:     (r_qlen == '0),
                      is_punct:    is_p,
                      resolve_hit: hit,
                      emit_last:   (r_ridx == res_k - CntW'(1)),
                      req_done:    (r_ridx <= res_k),
                      pend_valid:  r_pend_valid};

endmodule
`default_nettype wire

// File: hdl/tlex_ctrl.sv
// Lexer controller: sequences byte processing, match resolution and end-of-input flush.
`default_nettype none
module tlex_ctrl
    import tlex_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire logic  i_in_end,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PROC   = 3'd1;
    localparam logic [2:0] S_EMIT   = 3'd2;
    localparam logic [2:0] S_REQ    = 3'd3;
    localparam logic [2:0] S_FLUSH  = 3'd4;
    localparam logic [2:0] S_ENDTOK = 3'd5;
    localparam logic [2:0] S_CLOSE  = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_flush, n_flush;
    t_cmd       cmd_raw;
    logic       adv;

    assign o_in_ready = (r_state == S_IDLE);
    assign adv        = i_stat.go || (r_state == S_IDLE);

    always_comb begin
        cmd_raw = '0;
        n_state = r_state;
        n_flush = r_flush;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    // an end beat carries no byte to lex
                    cmd_raw.load = !i_in_end;
                    n_flush      = i_in_end;
                    n_state      = i_in_end ? S_FLUSH : S_PROC;
                end
            end
            S_PROC: begin
                if (i_stat.q_empty) begin
                    n_state = r_flush ? S_FLUSH : S_CLOSE;
                end else begin
                    cmd_raw.proc = 1'b1;
                    if (i_stat.resolve_hit) n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                cmd_raw.res_emit = 1'b1;
                if (i_stat.emit_last) n_state = S_REQ;
            end
            S_REQ: begin
                cmd_raw.res_req = 1'b1;
                if (i_stat.req_done) n_state = S_PROC;
            end
            S_FLUSH: begin
                if (i_stat.is_punct) begin
                    n_state = S_EMIT;
                end else begin
                    cmd_raw.fin_mode = 1'b1;
                    n_state          = S_ENDTOK;
                end
            end
            S_ENDTOK: begin
                cmd_raw.end_tok = 1'b1;
                n_state         = S_CLOSE;
            end
            S_CLOSE: begin
                cmd_raw.close = 1'b1;
                n_flush       = 1'b0;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // hold everything while the result stages are full
    assign o_cmd = adv ? cmd_raw : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_flush <= 1'b0;
        end else if (adv) begin
            r_state <= n_state;
            r_flush <= n_flush;
        end
    end

endmodule
`default_nettype wire
